// ----- sv/assert_macros.svh -----
// Assertion macros for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- sv/dfpc_pkg.sv -----
// Package with payload types and constants for the double/fixed converter.
`default_nettype none
package dfpc_pkg;

    localparam int unsigned TopBitWeightLog2 = 23;
    localparam logic        CmdToFixed       = 1'b0;
    localparam logic        CmdToDouble      = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result;
        logic        saturated;
    } t_out_item;

endpackage
`default_nettype wire

// ----- sv/dfpc_stage1.sv -----
// First stage: field decode and leading-one search over the fixed word.
`default_nettype none
module dfpc_stage1 #(
    parameter int unsigned TOP_BIT_WEIGHT_LOG2 = dfpc_pkg::TopBitWeightLog2
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire dfpc_pkg::t_in_item i_item,
    output logic                   o_cmd,
    output logic [63:0]            o_opnd,
    output logic [5:0]             o_lead,
    output logic                   o_zero,
    output logic                   o_neg_or_nan,
    output logic                   o_sat,
    output logic signed [12:0]     o_shift
);
    import dfpc_pkg::*;

    logic [10:0]        w_e;
    logic [51:0]        w_m;
    logic [5:0]         w_lead;
    logic signed [12:0] w_scale;

    // Leading one position of the operand; only meaningful for nonzero values.
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < 64; i++) begin
            if (i_item.operand[i]) begin
                w_lead = 6'(i);
            end
        end
    end

    // Decode exponent and compute the shift toward the fixed word.
    assign w_e = i_item.operand[62:52];
    assign w_m = i_item.operand[51:0];
    always_comb begin
        if (w_e == 11'd0) begin
            w_scale = -13'sd1074;
        end else begin
            w_scale = $signed({2'b00, w_e}) - 13'sd1075;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cmd        <= i_item.command;
            o_opnd       <= i_item.operand;
            o_lead       <= w_lead;
            o_zero       <= (i_item.operand == 64'd0);
            o_neg_or_nan <= i_item.operand[63] || ((w_e == 11'h7FF) && (w_m != 52'd0));
            o_sat        <= (w_e != 11'd0) &&
                ($signed({2'b00, w_e}) - 13'sd1023 >=
                 $signed(13'(TOP_BIT_WEIGHT_LOG2 + 1)));
            o_shift      <= w_scale + $signed(13'(63 - TOP_BIT_WEIGHT_LOG2));
        end
    end
endmodule
`default_nettype wire

// ----- sv/dfpc_stage2.sv -----
// Second stage: mantissa shifts for both directions.
`default_nettype none
module dfpc_stage2 (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [63:0]   i_opnd,
    input  wire logic [5:0]    i_lead,
    input  wire logic signed [12:0] i_shift,
    output logic [63:0]        o_fixed,
    output logic [52:0]        o_mant,
    output logic               o_round_up
);
    logic [52:0]  w_mant_dbl;
    logic [63:0]  w_fixed;
    logic [52:0]  w_trunc;
    logic [63:0]  w_rem;
    logic [63:0]  w_half;
    logic [63:0]  w_norm;
    logic [5:0]   w_d;

    // Double to fixed: shift the mantissa left or right by the scale.
    assign w_mant_dbl = {(i_opnd[62:52] != 11'd0), i_opnd[51:0]};
    always_comb begin
        if (i_shift >= 0) begin
            w_fixed = (i_shift >= 13'sd64) ? '1 : ({11'd0, w_mant_dbl} << i_shift[5:0]);
        end else if (i_shift <= -13'sd64) begin
            w_fixed = '0;
        end else begin
            w_fixed = {11'd0, w_mant_dbl} >> 6'(-i_shift);
        end
    end

    // Fixed to double: normalize so the leading one lands at bit 63.
    assign w_norm = i_opnd << (6'd63 - i_lead);
    assign w_d    = (i_lead > 6'd52) ? (i_lead - 6'd52) : 6'd0;
    assign w_trunc = w_norm[63:11];
    assign w_rem   = (w_d == 6'd0) ? 64'd0 : (i_opnd & ((64'd1 << w_d) - 64'd1));
    assign w_half  = (w_d == 6'd0) ? 64'd1 : (64'd1 << (w_d - 6'd1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_fixed    <= w_fixed;
            o_mant     <= w_trunc;
            o_round_up <= (w_d != 6'd0) &&
                ((w_rem > w_half) || ((w_rem == w_half) && w_trunc[0]));
        end
    end
endmodule
`default_nettype wire

// ----- sv/double_fixed_point_converter.sv -----
// Top level of the double/fixed-point converter pipeline.
//
// Converts IEEE-754 doubles to an unsigned 64-bit fixed word (top bit weighs
// 2^TOP_BIT_WEIGHT_LOG2, truncation, saturation flag) and back (round to
// nearest even). One item is accepted per cycle while no stall holds the
// pipeline. Each item passes through three register stages (decode and
// leading-one search, mantissa shifts, rounding and packing), the first of
// which loads at the accepting edge; the last stage presents its result.
// A stall holds all stages together; the input stalls only while the output
// stalls with a valid item in the last stage.
`default_nettype none
module double_fixed_point_converter #(
    parameter int unsigned TOP_BIT_WEIGHT_LOG2 = dfpc_pkg::TopBitWeightLog2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire dfpc_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output dfpc_pkg::t_out_item      o_item
);
    import dfpc_pkg::*;

    logic [2:0] r_vld;
    logic [2:0] n_vld;
    logic       w_en;

    logic               s1_cmd, s1_zero, s1_neg_or_nan, s1_sat;
    logic [63:0]        s1_opnd;
    logic [5:0]         s1_lead;
    logic signed [12:0] s1_shift;

    logic [63:0] s2_fixed;
    logic [52:0] s2_mant;
    logic        s2_round_up;
    logic        r_cmd2, r_zero2, r_neg2, r_sat2;
    logic [5:0]  r_lead2;

    t_out_item   r_out;
    t_out_item   n_out;
    logic [53:0] w_mant_r;
    logic [6:0]  w_k;
    logic [10:0] w_bexp;

    // The whole pipeline advances unless the output item is held.
    assign w_en    = !(r_vld[2] && i_stall);
    assign o_stall = !w_en;
    assign n_vld   = {r_vld[1], r_vld[0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    dfpc_stage1 #(.TOP_BIT_WEIGHT_LOG2(TOP_BIT_WEIGHT_LOG2)) u_stage1 (
        .i_clk(i_clk), .i_en(w_en), .i_item(i_item),
        .o_cmd(s1_cmd), .o_opnd(s1_opnd), .o_lead(s1_lead), .o_zero(s1_zero),
        .o_neg_or_nan(s1_neg_or_nan), .o_sat(s1_sat), .o_shift(s1_shift)
    );

    dfpc_stage2 u_stage2 (
        .i_clk(i_clk), .i_en(w_en), .i_opnd(s1_opnd), .i_lead(s1_lead),
        .i_shift(s1_shift), .o_fixed(s2_fixed), .o_mant(s2_mant),
        .o_round_up(s2_round_up)
    );

    // Side-band flags travel beside the second stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd2  <= s1_cmd;
            r_zero2 <= s1_zero;
            r_neg2  <= s1_neg_or_nan;
            r_sat2  <= s1_sat;
            r_lead2 <= s1_lead;
        end
    end

    // Final stage: rounding increment, renormalize and pack the result.
    assign w_mant_r = {1'b0, s2_mant} + {53'd0, s2_round_up};
    assign w_k      = {1'b0, r_lead2} + {6'd0, w_mant_r[53]};
    assign w_bexp   = 11'(w_k) + 11'(1023 + TOP_BIT_WEIGHT_LOG2 - 63);

    always_comb begin
        n_out.saturated = 1'b0;
        if (r_cmd2 == CmdToDouble) begin
            if (r_zero2) begin
                n_out.result = '0;
            end else begin
                n_out.result = {1'b0, w_bexp,
                    (w_mant_r[53] ? w_mant_r[52:1] : w_mant_r[51:0])};
            end
        end else if (r_neg2) begin
            n_out.result = '0;
        end else if (r_sat2) begin
            n_out.result    = '1;
            n_out.saturated = 1'b1;
        end else begin
            n_out.result = s2_fixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[2];
    assign o_item  = r_out;

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `ASSERT_IMPLIES(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `ASSERT_NEXT(a_flow, i_clk, i_rst_n, !o_stall && r_vld[1], o_valid)
endmodule
`default_nettype wire

// ----- bench/double_fixed_point_converter_tb.sv -----
// Self-checking testbench for the double/fixed-point converter.
`default_nettype none
module double_fixed_point_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfpc_pkg::*;

    localparam int unsigned WeightLog2 = TopBitWeightLog2;
    localparam int          LatencyCycles = 3;
    localparam int          RandomItems = 550;
    localparam logic [63:0] AllOnes = {64{1'b1}};

    // Directed row: stimulus plus an optional typed-in expectation.
    typedef struct {
        logic        command;
        logic [63:0] operand;
        bit          has_expect;
        logic [63:0] want_result;
        logic        want_saturated;
    } t_directed_row;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    t_out_item     pending_results[$];
    t_directed_row directed_rows[$];
    int            error_count;
    int            results_seen;
    int            to_fixed_count;
    int            to_double_count;
    int            saturated_count;

    double_fixed_point_converter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    // Free-running clock, 8 ns period.
    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Double bits to fixed word: truncate toward zero, saturate when too large.
    function automatic t_out_item convert_to_fixed(logic [63:0] bits);
        t_out_item   res;
        int          expo;
        int          shift;
        logic [63:0] mant;
        res.result = '0;
        res.saturated = 1'b0;
        expo = int'(bits[62:52]);
        if (bits[63]) return res;
        if (expo == 2047 && bits[51:0] != 0) return res;
        if (expo != 0 && expo - 1023 >= int'(WeightLog2) + 1) begin
            res.result = AllOnes;
            res.saturated = 1'b1;
            return res;
        end
        mant = {12'd0, bits[51:0]};
        if (expo != 0) mant[52] = 1'b1;
        shift = (expo == 0 ? -1074 : expo - 1075) + 63 - int'(WeightLog2);
        if (mant == 0) return res;
        if (shift >= 64) res.result = AllOnes;
        else if (shift >= 0) res.result = mant << shift;
        else if (-shift < 64) res.result = mant >> (-shift);
        return res;
    endfunction

    // Fixed word to double bits: round to nearest, ties to even.
    function automatic t_out_item fixed_word_to_double(logic [63:0] word);
        t_out_item   res;
        int          lead;
        int          drop;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        res.result = '0;
        res.saturated = 1'b0;
        if (word == 0) return res;
        lead = 63;
        while (!word[lead]) lead--;
        if (lead <= 52) begin
            mant = word << (52 - lead);
        end else begin
            drop = lead - 52;
            rem = word & ((64'd1 << drop) - 64'd1);
            half = 64'd1 << (drop - 1);
            mant = word >> drop;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant[53]) begin
                mant = mant >> 1;
                lead++;
            end
        end
        res.result = {1'b0, 11'(lead + int'(WeightLog2) - 63 + 1023), mant[51:0]};
        return res;
    endfunction

    function automatic t_out_item convert_item(t_in_item item);
        return item.command == CmdToDouble ? fixed_word_to_double(item.operand)
                                           : convert_to_fixed(item.operand);
    endfunction

    // Often no gap, otherwise mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random double with a bias toward exponents near the fixed range.
    function automatic logic [63:0] random_double();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1, 2: bits[62:52] = 11'($urandom_range(1023 - 45, 1023 + 26));
            3: bits[62:52] = $urandom_range(0, 1) ? 11'd0 : 11'd2047;
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) bits[63] = 1'b0;
        return bits;
    endfunction

    // Random fixed word with a random number of leading zeros and tie patterns.
    function automatic logic [63:0] random_fixed();
        logic [63:0] word;
        word = {$urandom, $urandom};
        word = word >> $urandom_range(0, 63);
        if ($urandom_range(0, 4) == 0) word[9:0] = 10'b1000000000;
        return word;
    endfunction

    task automatic add_row(logic cmd, logic [63:0] op, bit known = 1'b0,
                           logic [63:0] res = '0, logic sat = 1'b0);
        t_directed_row row;
        row.command = cmd;
        row.operand = op;
        row.has_expect = known;
        row.want_result = res;
        row.want_saturated = sat;
        directed_rows.push_back(row);
    endtask

    // Send one item and queue its expected result; returns at the accepting edge.
    task automatic send_item(t_in_item item, bit known, t_out_item want);
        int gap;
        gap = gap_length();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_item <= item;
        in_valid <= 1'b1;
        pending_results.push_back(known ? want : convert_item(item));
        if (item.command == CmdToDouble) to_double_count++;
        else to_fixed_count++;
        do @(posedge clk); while (in_stall);
    endtask

    // Output side: random stall at each falling edge.
    always @(negedge clk) begin
        if (rst_n) out_stall <= ($urandom_range(0, 99) < 30);
    end

    // Output side: compare every accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h sat %b", $time,
                         out_item.result, out_item.saturated);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_item.saturated) saturated_count++;
                if (out_item.result !== want.result) begin
                    $display("%0t: result expected %h actual %h", $time,
                             want.result, out_item.result);
                    error_count++;
                end
                if (out_item.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, out_item.saturated);
                    error_count++;
                end
            end
        end
    end

    // Main stimulus.
    initial begin
        t_in_item  item;
        t_out_item want;
        int        wait_cycles;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        results_seen = 0;
        to_fixed_count = 0;
        to_double_count = 0;
        saturated_count = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: signs, NaN, infinities, zeros, range edges, ties.
        add_row(CmdToFixed, 64'h0000_0000_0000_0000, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'h8000_0000_0000_0000, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'hBFF0_0000_0000_0000, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'hFFF0_0000_0000_0000, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'h7FF8_0000_0000_0000, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'h7FF0_0000_0000_0001, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'h7FF0_0000_0000_0000, 1'b1, AllOnes, 1'b1);
        add_row(CmdToFixed, 64'h4170_0000_0000_0000, 1'b1, AllOnes, 1'b1);
        add_row(CmdToFixed, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1, AllOnes, 1'b1);
        add_row(CmdToFixed, 64'h416F_FFFF_FFFF_FFFF);
        add_row(CmdToFixed, 64'h4160_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000);
        add_row(CmdToFixed, 64'h3FF0_0000_0000_0000, 1'b1, 64'h0000_0100_0000_0000);
        add_row(CmdToFixed, 64'h3D70_0000_0000_0000, 1'b1, 64'd1);
        add_row(CmdToFixed, 64'h3D6F_FFFF_FFFF_FFFF, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'h0000_0000_0000_0001, 1'b1, 64'd0);
        add_row(CmdToFixed, 64'h000F_FFFF_FFFF_FFFF, 1'b1, 64'd0);
        add_row(CmdToDouble, 64'd0, 1'b1, 64'd0);
        add_row(CmdToDouble, 64'd1, 1'b1, 64'h3D70_0000_0000_0000);
        add_row(CmdToDouble, 64'h0000_0100_0000_0000, 1'b1, 64'h3FF0_0000_0000_0000);
        add_row(CmdToDouble, AllOnes, 1'b1, 64'h4170_0000_0000_0000);
        add_row(CmdToDouble, 64'h8000_0000_0000_0400);
        add_row(CmdToDouble, 64'h8000_0000_0000_0C00);
        add_row(CmdToDouble, 64'h8000_0000_0000_0401);
        add_row(CmdToDouble, 64'h001F_FFFF_FFFF_FFFF);
        foreach (directed_rows[i]) begin
            item.command = directed_rows[i].command;
            item.operand = directed_rows[i].operand;
            want.result = directed_rows[i].want_result;
            want.saturated = directed_rows[i].want_saturated;
            send_item(item, directed_rows[i].has_expect, want);
        end

        // Random part: both directions mixed.
        for (int n = 0; n < RandomItems; n++) begin
            item.command = $urandom_range(0, 1) ? CmdToDouble : CmdToFixed;
            item.operand = item.command == CmdToDouble ? random_fixed() : random_double();
            if ($urandom_range(0, 9) == 0) item.operand = {$urandom, $urandom};
            send_item(item, 1'b0, want);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then allow the pipeline latency to expose stray results.
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LatencyCycles + 10) @(posedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            error_count++;
        end

        $display("Covered %0d double-to-fixed and %0d fixed-to-double items,",
                 to_fixed_count, to_double_count);
        $display("with %0d results checked and %0d saturated outputs.",
                 results_seen, saturated_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2ms;
        $display("Timeout waiting for the converter.");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/dfpc_pkg.sv
sv/dfpc_stage1.sv
sv/dfpc_stage2.sv
sv/double_fixed_point_converter.sv
bench/double_fixed_point_converter_tb.sv
